// ----- rtl/nearest_neighbor_blit_addresser_assert.svh -----
// Assertion macros used by the blit addresser back end, nnba_back.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef NEAREST_NEIGHBOR_BLIT_ADDRESSER_ASSERT_SVH
`define NEAREST_NEIGHBOR_BLIT_ADDRESSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define NNBA_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define NNBA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/nnba_pkg.sv -----
// Package for the nearest-neighbor blit addresser: register codes, fixed widths,
// parameter defaults and the back-end state type. Depends on nothing.
`timescale 1ns / 1ps

package nnba_pkg;

    localparam int PITCH_BITS     = 16;
    localparam int ROWS_BITS      = 13;
    localparam int WIN_BITS       = 48;
    localparam int BPP_REG_BITS   = 3;
    localparam int CFG_DATA_BITS  = 48;
    localparam int CFG_INDEX_BITS = 3;
    localparam int QUEUE_DEPTH    = 2;

    localparam int COORD_BITS_DEF      = 12;
    localparam int ADDR_BITS_DEF       = 28;
    localparam int MAX_PIXEL_BYTES_DEF = 4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SRC_PITCH  = 3'd0,
        REG_SRC_ROWS   = 3'd1,
        REG_SRC_WINDOW = 3'd2,
        REG_TRG_PITCH  = 3'd3,
        REG_TRG_ROWS   = 3'd4,
        REG_TRG_WINDOW = 3'd5,
        REG_BPP        = 3'd6,
        REG_MIRROR     = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ROW_LD,
        BK_ROW_WAIT,
        BK_COL_LD,
        BK_COL_WAIT,
        BK_LINE,
        BK_MUL,
        BK_SUM
    } back_state_t;

endpackage

// ----- rtl/nearest_neighbor_blit_addresser.sv -----
// Top level of the nearest-neighbor blit addresser: configuration registers,
// front end, position queue and back end. Uses nnba_pkg, nnba_front,
// nnba_fifo and nnba_back.
`timescale 1ns / 1ps

// Each step beat yields one result beat holding a source and a target byte
// address for a nearest-neighbor scaling copy, walking target rows, then
// columns, then the bytes of a pixel. The front end takes a step beat whenever
// the queue has room and can run two beats ahead of the back end through a
// two-entry queue. In the back end a beat that is not a real copy step goes
// straight to the sum state, and a step whose source row and column are
// already known passes through operand fetch, address multiply and sum. A new
// target column adds one pass of the shared divider, and a new target row adds
// another. The divider results are kept between steps and dropped on any
// configuration write.

module nearest_neighbor_blit_addresser
    import nnba_pkg::*;
#(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int ADDR_BITS       = ADDR_BITS_DEF,
    parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      step_valid,
    output logic                      step_ready,
    input  logic                      restart,
    output logic                      res_valid,
    input  logic                      res_ready,
    output logic [ADDR_BITS-1:0]      src_addr,
    output logic [ADDR_BITS-1:0]      trg_addr,
    output logic                      valid_res,
    output logic                      last
);

    localparam int ByteBits = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int PbBits   = $clog2(MAX_PIXEL_BYTES + 1);
    localparam int EntBits  = 2 * COORD_BITS + ByteBits + 2;
    localparam int WinWide  = (4 * COORD_BITS > WIN_BITS) ? 4 * COORD_BITS : WIN_BITS;

    logic [PITCH_BITS-1:0]   src_pitch_reg;
    logic [ROWS_BITS-1:0]    src_rows_reg;
    logic [WIN_BITS-1:0]     src_window_reg;
    logic [PITCH_BITS-1:0]   trg_pitch_reg;
    logic [ROWS_BITS-1:0]    trg_rows_reg;
    logic [WIN_BITS-1:0]     trg_window_reg;
    logic [BPP_REG_BITS-1:0] bpp_reg;
    logic                    mirror_reg;

    logic [WinWide-1:0]      src_win_wide;
    logic [WinWide-1:0]      trg_win_wide;
    logic [COORD_BITS-1:0]   sx;
    logic [COORD_BITS-1:0]   sy;
    logic [COORD_BITS-1:0]   sw;
    logic [COORD_BITS-1:0]   sh;
    logic [COORD_BITS-1:0]   tx;
    logic [COORD_BITS-1:0]   ty;
    logic [COORD_BITS-1:0]   tw;
    logic [COORD_BITS-1:0]   th;
    logic [PbBits-1:0]       bpp;

    logic                    push_valid;
    logic                    push_ready;
    logic                    f_valid;
    logic                    f_last;
    logic [COORD_BITS-1:0]   f_row;
    logic [COORD_BITS-1:0]   f_col;
    logic [ByteBits-1:0]     f_byte;
    logic [EntBits-1:0]      push_data;
    logic                    pop_valid;
    logic                    pop_ready;
    logic [EntBits-1:0]      pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_pitch_reg  <= '0;
            src_rows_reg   <= '0;
            src_window_reg <= '0;
            trg_pitch_reg  <= '0;
            trg_rows_reg   <= '0;
            trg_window_reg <= '0;
            bpp_reg        <= BPP_REG_BITS'(1);
            mirror_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SRC_PITCH:  src_pitch_reg  <= cfg_data[PITCH_BITS-1:0];
                REG_SRC_ROWS:   src_rows_reg   <= cfg_data[ROWS_BITS-1:0];
                REG_SRC_WINDOW: src_window_reg <= cfg_data[WIN_BITS-1:0];
                REG_TRG_PITCH:  trg_pitch_reg  <= cfg_data[PITCH_BITS-1:0];
                REG_TRG_ROWS:   trg_rows_reg   <= cfg_data[ROWS_BITS-1:0];
                REG_TRG_WINDOW: trg_window_reg <= cfg_data[WIN_BITS-1:0];
                REG_BPP:        bpp_reg        <= cfg_data[BPP_REG_BITS-1:0];
                REG_MIRROR:     mirror_reg     <= cfg_data[0];
                default:        mirror_reg     <= mirror_reg;
            endcase
        end
    end

    assign src_win_wide = WinWide'(src_window_reg);
    assign trg_win_wide = WinWide'(trg_window_reg);
    assign sx = src_win_wide[0 +: COORD_BITS];
    assign sy = src_win_wide[COORD_BITS +: COORD_BITS];
    assign sw = src_win_wide[2*COORD_BITS +: COORD_BITS];
    assign sh = src_win_wide[3*COORD_BITS +: COORD_BITS];
    assign tx = trg_win_wide[0 +: COORD_BITS];
    assign ty = trg_win_wide[COORD_BITS +: COORD_BITS];
    assign tw = trg_win_wide[2*COORD_BITS +: COORD_BITS];
    assign th = trg_win_wide[3*COORD_BITS +: COORD_BITS];

    // A pixel size of zero counts as one byte; larger sizes clamp to the maximum.
    always_comb
    begin
        if (bpp_reg == '0)
        begin
            bpp = PbBits'(1);
        end
        else if (32'(bpp_reg) > 32'(MAX_PIXEL_BYTES))
        begin
            bpp = PbBits'(MAX_PIXEL_BYTES);
        end
        else
        begin
            bpp = PbBits'(bpp_reg);
        end
    end

    nnba_front #(
        .COORD_BITS      (COORD_BITS),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (step_valid),
        .step_ready (step_ready),
        .restart    (restart),
        .tw         (tw),
        .th         (th),
        .bpp        (bpp),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .ent_valid  (f_valid),
        .ent_last   (f_last),
        .ent_row    (f_row),
        .ent_col    (f_col),
        .ent_byte   (f_byte)
    );

    assign push_data = {f_valid, f_last, f_row, f_col, f_byte};

    nnba_fifo #(
        .WIDTH (EntBits),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    nnba_back #(
        .COORD_BITS      (COORD_BITS),
        .ADDR_BITS       (ADDR_BITS),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .src_pitch (src_pitch_reg),
        .src_rows  (src_rows_reg),
        .sx        (sx),
        .sy        (sy),
        .sw        (sw),
        .sh        (sh),
        .trg_pitch (trg_pitch_reg),
        .trg_rows  (trg_rows_reg),
        .tx        (tx),
        .ty        (ty),
        .tw        (tw),
        .th        (th),
        .bpp       (bpp),
        .mirror    (mirror_reg),
        .ent_valid (pop_valid),
        .ent_ready (pop_ready),
        .ent_data  (pop_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .src_addr  (src_addr),
        .trg_addr  (trg_addr),
        .valid_res (valid_res),
        .last      (last)
    );

endmodule

// ----- rtl/nnba_fifo.sv -----
// Short queue of walk positions between the front and back ends.
// Takes its default depth from nnba_pkg.
`timescale 1ns / 1ps

module nnba_fifo
    import nnba_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntBits = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   mem_reg [DEPTH];
    logic [PtrBits-1:0] wr_ptr_reg;
    logic [PtrBits-1:0] rd_ptr_reg;
    logic [CntBits-1:0] count_reg;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != CntBits'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/nnba_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
// Divides a 2*COORD_BITS numerator by a COORD_BITS divisor; uses nnba_pkg.
`timescale 1ns / 1ps

module nnba_div
    import nnba_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [2*COORD_BITS-1:0] num,
    input  logic [COORD_BITS-1:0]   den,
    output logic                    done,
    output logic [2*COORD_BITS-1:0] quo
);

    localparam int NumBits = 2 * COORD_BITS;
    localparam int CntBits = $clog2(NumBits + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CntBits-1:0]    cnt_reg;
    logic [NumBits-1:0]    quo_reg;
    logic [COORD_BITS-1:0] rem_reg;
    logic [COORD_BITS-1:0] den_reg;
    logic [COORD_BITS:0]   trial;
    logic [COORD_BITS:0]   diff;
    logic                  ge;

    assign trial = {rem_reg, quo_reg[NumBits-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});
    assign done  = done_reg;
    assign quo   = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntBits'(NumBits);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntBits'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NumBits-2:0], ge};
            rem_reg <= ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
        end
    end

endmodule

// ----- rtl/nnba_front.sv -----
// Front end: takes step beats, advances the row/column/byte walk and marks
// each position as a real copy step or not. Uses nnba_pkg.
`timescale 1ns / 1ps

module nnba_front
    import nnba_pkg::*;
#(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     step_valid,
    output logic                                     step_ready,
    input  logic                                     restart,
    input  logic [COORD_BITS-1:0]                    tw,
    input  logic [COORD_BITS-1:0]                    th,
    input  logic [$clog2(MAX_PIXEL_BYTES+1)-1:0]     bpp,
    output logic                                     push_valid,
    input  logic                                     push_ready,
    output logic                                     ent_valid,
    output logic                                     ent_last,
    output logic [COORD_BITS-1:0]                    ent_row,
    output logic [COORD_BITS-1:0]                    ent_col,
    output logic [((MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1)-1:0] ent_byte
);

    localparam int ByteBits = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    logic [COORD_BITS-1:0] row_reg;
    logic [COORD_BITS-1:0] col_reg;
    logic [ByteBits-1:0]   byte_reg;
    logic                  done_reg;
    logic [COORD_BITS-1:0] row_next;
    logic [COORD_BITS-1:0] col_next;
    logic [ByteBits-1:0]   byte_next;
    logic                  done_next;
    logic [COORD_BITS:0]   r_w;
    logic [COORD_BITS:0]   c_w;
    logic [ByteBits:0]     b_w;
    logic                  dims_zero;
    logic                  accept;

    assign step_ready = push_ready;
    assign push_valid = step_valid;
    assign accept     = step_valid && step_ready;
    assign dims_zero  = (tw == '0) || (th == '0);

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        byte_next = byte_reg;
        done_next = done_reg;
        r_w       = {1'b0, row_reg};
        c_w       = {1'b0, col_reg};
        b_w       = {1'b0, byte_reg} + 1'b1;
        if (restart)
        begin
            row_next  = '0;
            col_next  = '0;
            byte_next = '0;
            done_next = dims_zero;
        end
        else if (!done_reg)
        begin
            if (dims_zero)
            begin
                done_next = 1'b1;
            end
            else
            begin
                if (32'(b_w) >= 32'(bpp))
                begin
                    b_w = '0;
                    c_w = {1'b0, col_reg} + 1'b1;
                end
                if (c_w >= {1'b0, tw})
                begin
                    c_w = '0;
                    r_w = {1'b0, row_reg} + 1'b1;
                end
                if (r_w >= {1'b0, th})
                begin
                    r_w       = '0;
                    c_w       = '0;
                    b_w       = '0;
                    done_next = 1'b1;
                end
                row_next  = r_w[COORD_BITS-1:0];
                col_next  = c_w[COORD_BITS-1:0];
                byte_next = b_w[ByteBits-1:0];
            end
        end
    end

    assign ent_valid = !done_next;
    assign ent_row   = row_next;
    assign ent_col   = col_next;
    assign ent_byte  = byte_next;
    assign ent_last  = !done_next
                       && (32'(byte_next) == 32'(bpp) - 32'd1)
                       && (col_next == tw - COORD_BITS'(1))
                       && (row_next == th - COORD_BITS'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            byte_reg <= '0;
            done_reg <= 1'b1;
        end
        else if (accept)
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            byte_reg <= byte_next;
            done_reg <= done_next;
        end
    end

endmodule

// ----- rtl/nnba_back.sv -----
// Back end: scales each walk position to source coordinates through a shared
// divider, forms both byte addresses and holds the result beat. Uses nnba_pkg
// and nnba_div.
`timescale 1ns / 1ps
`include "nearest_neighbor_blit_addresser_assert.svh"

module nnba_back
    import nnba_pkg::*;
#(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int ADDR_BITS       = ADDR_BITS_DEF,
    parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [PITCH_BITS-1:0]                src_pitch,
    input  logic [ROWS_BITS-1:0]                 src_rows,
    input  logic [COORD_BITS-1:0]                sx,
    input  logic [COORD_BITS-1:0]                sy,
    input  logic [COORD_BITS-1:0]                sw,
    input  logic [COORD_BITS-1:0]                sh,
    input  logic [PITCH_BITS-1:0]                trg_pitch,
    input  logic [ROWS_BITS-1:0]                 trg_rows,
    input  logic [COORD_BITS-1:0]                tx,
    input  logic [COORD_BITS-1:0]                ty,
    input  logic [COORD_BITS-1:0]                tw,
    input  logic [COORD_BITS-1:0]                th,
    input  logic [$clog2(MAX_PIXEL_BYTES+1)-1:0] bpp,
    input  logic                                 mirror,
    input  logic                                 ent_valid,
    output logic                                 ent_ready,
    input  logic [2*COORD_BITS+1+((MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1):0] ent_data,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic [ADDR_BITS-1:0]                 src_addr,
    output logic [ADDR_BITS-1:0]                 trg_addr,
    output logic                                 valid_res,
    output logic                                 last
);

    localparam int ByteBits = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int NumBits  = 2 * COORD_BITS;
    localparam int ColLo    = ByteBits;
    localparam int RowLo    = ByteBits + COORD_BITS;
    localparam int LastPos  = ByteBits + 2 * COORD_BITS;
    localparam int ValidPos = LastPos + 1;

    back_state_t state_reg;
    back_state_t state_next;

    logic                  in_ok;
    logic                  in_last;
    logic [COORD_BITS-1:0] in_row;
    logic [COORD_BITS-1:0] in_col;
    logic [ByteBits-1:0]   in_byte;

    logic                  e_valid_reg;
    logic                  e_last_reg;
    logic [COORD_BITS-1:0] e_row_reg;
    logic [COORD_BITS-1:0] e_col_reg;
    logic [ByteBits-1:0]   e_byte_reg;

    logic [NumBits-1:0]    fy_reg;
    logic [NumBits-1:0]    fx_reg;
    logic [COORD_BITS-1:0] fy_row_reg;
    logic [COORD_BITS-1:0] fx_col_reg;
    logic                  fy_ok_reg;
    logic                  fx_ok_reg;

    logic [ADDR_BITS-1:0]  s_line_reg;
    logic [ADDR_BITS-1:0]  t_line_reg;
    logic [ADDR_BITS-1:0]  s_col_reg;
    logic [ADDR_BITS-1:0]  t_col_reg;
    logic [ADDR_BITS-1:0]  s_base_reg;
    logic [ADDR_BITS-1:0]  t_base_reg;
    logic [ADDR_BITS-1:0]  s_off_reg;
    logic [ADDR_BITS-1:0]  t_off_reg;

    logic                  res_valid_reg;
    logic [ADDR_BITS-1:0]  src_addr_reg;
    logic [ADDR_BITS-1:0]  trg_addr_reg;
    logic                  valid_res_reg;
    logic                  last_reg;

    logic                  div_start;
    logic [NumBits-1:0]    div_num;
    logic [COORD_BITS-1:0] div_den;
    logic                  div_done;
    logic [NumBits-1:0]    div_quo;

    logic                  fy_stale_in;
    logic                  fx_stale_in;
    logic                  fx_stale;
    logic                  out_free;
    logic                  pop;

    logic [ADDR_BITS-1:0]  one_a;
    logic [ADDR_BITS-1:0]  src_pitch_a;
    logic [ADDR_BITS-1:0]  trg_pitch_a;
    logic [ADDR_BITS-1:0]  bpp_a;
    logic [ADDR_BITS-1:0]  s_line_next;
    logic [ADDR_BITS-1:0]  t_line_next;
    logic [ADDR_BITS-1:0]  t_col_next;

    function automatic logic rows_positive(input logic [ROWS_BITS-1:0] rows);
        rows_positive = (rows != '0) && !rows[ROWS_BITS-1];
    endfunction

    assign in_ok   = ent_data[ValidPos];
    assign in_last = ent_data[LastPos];
    assign in_row  = ent_data[RowLo +: COORD_BITS];
    assign in_col  = ent_data[ColLo +: COORD_BITS];
    assign in_byte = ent_data[ByteBits-1:0];

    assign fy_stale_in = !fy_ok_reg || (fy_row_reg != in_row);
    assign fx_stale_in = !fx_ok_reg || (fx_col_reg != in_col);
    assign fx_stale    = !fx_ok_reg || (fx_col_reg != e_col_reg);
    assign out_free    = !res_valid_reg || res_ready;
    assign pop         = ent_valid && ent_ready;

    nnba_div #(
        .COORD_BITS (COORD_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (ent_valid)
                begin
                    if (!in_ok)
                    begin
                        state_next = BK_SUM;
                    end
                    else if (fy_stale_in)
                    begin
                        state_next = BK_ROW_LD;
                    end
                    else if (fx_stale_in)
                    begin
                        state_next = BK_COL_LD;
                    end
                    else
                    begin
                        state_next = BK_LINE;
                    end
                end
            end
            BK_ROW_LD:
            begin
                state_next = BK_ROW_WAIT;
            end
            BK_ROW_WAIT:
            begin
                if (div_done)
                begin
                    state_next = fx_stale ? BK_COL_LD : BK_LINE;
                end
            end
            BK_COL_LD:
            begin
                state_next = BK_COL_WAIT;
            end
            BK_COL_WAIT:
            begin
                if (div_done)
                begin
                    state_next = BK_LINE;
                end
            end
            BK_LINE:
            begin
                state_next = BK_MUL;
            end
            BK_MUL:
            begin
                state_next = BK_SUM;
            end
            BK_SUM:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ent_ready = 1'b0;
        div_start = 1'b0;
        div_num   = NumBits'(sh) * NumBits'(e_row_reg);
        div_den   = th;
        unique case (state_reg)
            BK_IDLE:
            begin
                ent_ready = 1'b1;
            end
            BK_ROW_LD:
            begin
                div_start = 1'b1;
            end
            BK_COL_LD:
            begin
                div_start = 1'b1;
                div_num   = NumBits'(sw) * NumBits'(e_col_reg);
                div_den   = tw;
            end
            default:
            begin
                ent_ready = 1'b0;
            end
        endcase
    end

    assign one_a       = ADDR_BITS'(1);
    assign src_pitch_a = ADDR_BITS'(src_pitch);
    assign trg_pitch_a = ADDR_BITS'(trg_pitch);
    assign bpp_a       = ADDR_BITS'(bpp);

    always_comb
    begin
        if (rows_positive(src_rows))
        begin
            s_line_next = ADDR_BITS'(src_rows) - one_a - ADDR_BITS'(sy) - ADDR_BITS'(fy_reg);
        end
        else
        begin
            s_line_next = ADDR_BITS'(sy) + ADDR_BITS'(fy_reg);
        end
        if (rows_positive(trg_rows))
        begin
            t_line_next = ADDR_BITS'(trg_rows) - one_a - ADDR_BITS'(ty) - ADDR_BITS'(e_row_reg);
        end
        else
        begin
            t_line_next = ADDR_BITS'(ty) + ADDR_BITS'(e_row_reg);
        end
        if (mirror)
        begin
            t_col_next = ADDR_BITS'(tx) + ADDR_BITS'(tw) - one_a - ADDR_BITS'(e_col_reg);
        end
        else
        begin
            t_col_next = ADDR_BITS'(tx) + ADDR_BITS'(e_col_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            fy_ok_reg     <= 1'b0;
            fx_ok_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                fy_ok_reg <= 1'b0;
                fx_ok_reg <= 1'b0;
            end
            else
            begin
                if (state_reg == BK_ROW_WAIT && div_done)
                begin
                    fy_ok_reg <= 1'b1;
                end
                if (state_reg == BK_COL_WAIT && div_done)
                begin
                    fx_ok_reg <= 1'b1;
                end
            end
            if (state_reg == BK_SUM && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            e_valid_reg <= in_ok;
            e_last_reg  <= in_last;
            e_row_reg   <= in_row;
            e_col_reg   <= in_col;
            e_byte_reg  <= in_byte;
        end
        if (state_reg == BK_ROW_LD)
        begin
            fy_row_reg <= e_row_reg;
        end
        if (state_reg == BK_COL_LD)
        begin
            fx_col_reg <= e_col_reg;
        end
        if (state_reg == BK_ROW_WAIT && div_done)
        begin
            fy_reg <= div_quo;
        end
        if (state_reg == BK_COL_WAIT && div_done)
        begin
            fx_reg <= div_quo;
        end
        if (state_reg == BK_LINE)
        begin
            s_line_reg <= s_line_next;
            t_line_reg <= t_line_next;
            s_col_reg  <= ADDR_BITS'(sx) + ADDR_BITS'(fx_reg);
            t_col_reg  <= t_col_next;
        end
        if (state_reg == BK_MUL)
        begin
            s_base_reg <= s_line_reg * src_pitch_a;
            t_base_reg <= t_line_reg * trg_pitch_a;
            s_off_reg  <= s_col_reg * bpp_a;
            t_off_reg  <= t_col_reg * bpp_a;
        end
        if (state_reg == BK_SUM && out_free)
        begin
            valid_res_reg <= e_valid_reg;
            last_reg      <= e_valid_reg && e_last_reg;
            src_addr_reg  <= e_valid_reg ? s_base_reg + s_off_reg + ADDR_BITS'(e_byte_reg) : '0;
            trg_addr_reg  <= e_valid_reg ? t_base_reg + t_off_reg + ADDR_BITS'(e_byte_reg) : '0;
        end
    end

    assign res_valid = res_valid_reg;
    assign src_addr  = src_addr_reg;
    assign trg_addr  = trg_addr_reg;
    assign valid_res = valid_res_reg;
    assign last      = last_reg;

    `NNBA_ASSERT_IMPLY(a_invalid_beat_zero, res_valid_reg && !valid_res_reg, src_addr_reg == '0 && trg_addr_reg == '0 && !last_reg, "Invalid beat carries nonzero fields.")
    `NNBA_ASSERT_NEXT(a_row_quotient_cached, state_reg == BK_ROW_WAIT && div_done && !cfg_we, fy_ok_reg && fy_row_reg == e_row_reg, "Row quotient not cached after division.")
    `NNBA_ASSERT_NEXT(a_pop_leaves_idle, ent_valid && ent_ready, state_reg != BK_IDLE, "Back end stayed idle after taking an entry.")
    `NNBA_ASSERT_NEXT(a_sum_loads_output, state_reg == BK_SUM && out_free, res_valid_reg && state_reg == BK_IDLE, "Result beat not loaded on leaving the sum state.")

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for nearest_neighbor_blit_addresser: directed and random
// step beats, every result checked against a built-in address predictor.
// Depends on nnba_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_top;
    import nnba_pkg::*;

    localparam int AW         = ADDR_BITS_DEF;
    localparam int CW         = COORD_BITS_DEF;
    localparam int IDLE_LIMIT = 3000;
    localparam int STEP_GOAL  = 1200;
    localparam int PLAN_ROWS  = 29;

    typedef struct packed {
        logic [AW-1:0] src_addr;
        logic [AW-1:0] trg_addr;
        logic          valid_res;
        logic          last;
    } addr_pair_t;

    typedef enum logic {
        ROW_CFG,
        ROW_STEP
    } row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        cfg_reg_t                 reg_id;
        logic [CFG_DATA_BITS-1:0] data;
        logic                     rs;
        logic                     idle_result;
    } plan_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      step_valid;
    logic                      step_ready;
    logic                      restart;
    logic                      res_valid;
    logic                      res_ready;
    logic [AW-1:0]             src_addr;
    logic [AW-1:0]             trg_addr;
    logic                      valid_res;
    logic                      last;

    // Predictor copy of the registers and of the walk position.
    logic [PITCH_BITS-1:0]   p_src_pitch;
    logic [ROWS_BITS-1:0]    p_src_rows;
    logic [WIN_BITS-1:0]     p_src_win;
    logic [PITCH_BITS-1:0]   p_trg_pitch;
    logic [ROWS_BITS-1:0]    p_trg_rows;
    logic [WIN_BITS-1:0]     p_trg_win;
    logic [BPP_REG_BITS-1:0] p_bpp;
    logic                    p_mirror;
    logic [CW-1:0]           walk_row;
    logic [CW-1:0]           walk_col;
    logic [1:0]              walk_byte;
    logic                    walk_done;

    addr_pair_t pending_pairs[$];
    addr_pair_t head_pair;
    plan_row_t  directed_plan [PLAN_ROWS];
    int         mismatches = 0;
    int         quiet_cycles = 0;
    int         stall_left;
    int         stall_draw;
    bit         fast_sender = 1'b0;
    bit         fast_receiver = 1'b0;

    nearest_neighbor_blit_addresser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_valid(step_valid),
        .step_ready(step_ready),
        .restart   (restart),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .src_addr  (src_addr),
        .trg_addr  (trg_addr),
        .valid_res (valid_res),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [WIN_BITS-1:0] pack_window(int unsigned x, int unsigned y,
                                                        int unsigned w, int unsigned h);
        return {h[CW-1:0], w[CW-1:0], y[CW-1:0], x[CW-1:0]};
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] noise();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[CFG_DATA_BITS-1:0];
    endfunction

    function automatic int unsigned target_extent();
        int unsigned pick;
        pick = $urandom_range(0, 39);
        if (pick == 0)
        begin
            return 0;
        end
        if (pick == 1)
        begin
            return $urandom_range(0, 4095);
        end
        return $urandom_range(1, 6);
    endfunction

    function automatic plan_row_t cfg_row(cfg_reg_t r, logic [CFG_DATA_BITS-1:0] d);
        return '{kind: ROW_CFG, reg_id: r, data: d, rs: 1'b0, idle_result: 1'b0};
    endfunction

    function automatic plan_row_t step_row(logic rs, logic idle);
        return '{kind: ROW_STEP, reg_id: REG_SRC_PITCH, data: '0, rs: rs, idle_result: idle};
    endfunction

    function automatic int unsigned effective_bpp();
        int unsigned nb;
        nb = p_bpp;
        if (nb == 0)
        begin
            nb = 1;
        end
        if (nb > MAX_PIXEL_BYTES_DEF)
        begin
            nb = MAX_PIXEL_BYTES_DEF;
        end
        return nb;
    endfunction

    // Start of a buffer line; bottom-up buffers count lines down from the top.
    function automatic logic [63:0] line_offset(logic [ROWS_BITS-1:0] rows, logic [63:0] y,
                                                logic [63:0] line, logic [PITCH_BITS-1:0] pitch);
        logic [63:0] r;
        if (rows != '0 && !rows[ROWS_BITS-1])
        begin
            r = 64'(rows) - 64'd1 - y - line;
        end
        else
        begin
            r = y + line;
        end
        return r * 64'(pitch);
    endfunction

    function automatic addr_pair_t address_pair();
        logic [63:0] sx, sy, sw, sh, tx, ty, tw, th;
        logic [63:0] fy, fx, tcol, nb, sa, ta;
        addr_pair_t  pair;
        sx   = 64'(p_src_win[CW-1:0]);
        sy   = 64'(p_src_win[2*CW-1:CW]);
        sw   = 64'(p_src_win[3*CW-1:2*CW]);
        sh   = 64'(p_src_win[4*CW-1:3*CW]);
        tx   = 64'(p_trg_win[CW-1:0]);
        ty   = 64'(p_trg_win[2*CW-1:CW]);
        tw   = 64'(p_trg_win[3*CW-1:2*CW]);
        th   = 64'(p_trg_win[4*CW-1:3*CW]);
        nb   = 64'(effective_bpp());
        fy   = sh * 64'(walk_row) / th;
        fx   = sw * 64'(walk_col) / tw;
        tcol = p_mirror ? tx + tw - 64'd1 - 64'(walk_col) : tx + 64'(walk_col);
        sa   = line_offset(p_src_rows, sy, fy, p_src_pitch) + (sx + fx) * nb + 64'(walk_byte);
        ta   = line_offset(p_trg_rows, ty, 64'(walk_row), p_trg_pitch) + tcol * nb
               + 64'(walk_byte);
        pair.src_addr  = sa[AW-1:0];
        pair.trg_addr  = ta[AW-1:0];
        pair.valid_res = 1'b1;
        pair.last      = (64'(walk_byte) == nb - 64'd1) && (64'(walk_col) == tw - 64'd1)
                         && (64'(walk_row) == th - 64'd1);
        return pair;
    endfunction

    task automatic advance_walk(input logic rs, output addr_pair_t pair);
        logic [CW-1:0] tw;
        logic [CW-1:0] th;
        tw   = p_trg_win[3*CW-1:2*CW];
        th   = p_trg_win[4*CW-1:3*CW];
        pair = '0;
        if (rs)
        begin
            walk_row  = '0;
            walk_col  = '0;
            walk_byte = '0;
            walk_done = (tw == '0 || th == '0);
        end
        else if (!walk_done)
        begin
            if (tw == '0 || th == '0)
            begin
                walk_done = 1'b1;
            end
            else
            begin
                if (int'(walk_byte) + 1 >= effective_bpp())
                begin
                    walk_byte = '0;
                    walk_col  = walk_col + 1'b1;
                end
                else
                begin
                    walk_byte = walk_byte + 1'b1;
                end
                if (walk_col >= tw)
                begin
                    walk_col = '0;
                    walk_row = walk_row + 1'b1;
                end
                if (walk_row >= th)
                begin
                    walk_row  = '0;
                    walk_col  = '0;
                    walk_byte = '0;
                    walk_done = 1'b1;
                end
            end
        end
        if (!walk_done)
        begin
            pair = address_pair();
        end
    endtask

    task automatic cfg_write(input cfg_reg_t r, input logic [CFG_DATA_BITS-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= d;
        @(posedge clk);
        case (r)
            REG_SRC_PITCH:  p_src_pitch = d[PITCH_BITS-1:0];
            REG_SRC_ROWS:   p_src_rows  = d[ROWS_BITS-1:0];
            REG_SRC_WINDOW: p_src_win   = d[WIN_BITS-1:0];
            REG_TRG_PITCH:  p_trg_pitch = d[PITCH_BITS-1:0];
            REG_TRG_ROWS:   p_trg_rows  = d[ROWS_BITS-1:0];
            REG_TRG_WINDOW: p_trg_win   = d[WIN_BITS-1:0];
            REG_BPP:        p_bpp       = d[BPP_REG_BITS-1:0];
            REG_MIRROR:     p_mirror    = d[0];
            default:        ;
        endcase
    endtask

    task automatic send_step(input logic rs, input logic idle_result, output addr_pair_t pair);
        int gap;
        cfg_we <= 1'b0;
        gap = fast_sender ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            step_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        step_valid <= 1'b1;
        restart    <= rs;
        advance_walk(rs, pair);
        pending_pairs.push_back(idle_result ? addr_pair_t'('0) : pair);
        do @(posedge clk); while (!step_ready);
    endtask

    // Holds the sender back until every expected beat has come out.
    task automatic settle();
        step_valid <= 1'b0;
        do @(posedge clk); while (pending_pairs.size() != 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (res_valid && res_ready)
        begin
            if (pending_pairs.size() == 0)
            begin
                $error("result beat arrived with nothing pending");
                mismatches++;
            end
            else
            begin
                head_pair = pending_pairs.pop_front();
                if (src_addr !== head_pair.src_addr)
                begin
                    $error("src_addr: expected %h, got %h", head_pair.src_addr, src_addr);
                    mismatches++;
                end
                if (trg_addr !== head_pair.trg_addr)
                begin
                    $error("trg_addr: expected %h, got %h", head_pair.trg_addr, trg_addr);
                    mismatches++;
                end
                if (valid_res !== head_pair.valid_res)
                begin
                    $error("valid_res: expected %b, got %b", head_pair.valid_res, valid_res);
                    mismatches++;
                end
                if (last !== head_pair.last)
                begin
                    $error("last: expected %b, got %b", head_pair.last, last);
                    mismatches++;
                end
            end
            stall_draw = fast_receiver ? 0 : $urandom_range(0, 14);
            if (stall_draw != 0)
            begin
                res_ready  <= 1'b0;
                stall_left <= stall_draw - 1;
            end
        end
        else if (!res_ready)
        begin
            if (stall_left == 0)
            begin
                res_ready <= 1'b1;
            end
            else
            begin
                stall_left <= stall_left - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((step_valid && step_ready) || (res_valid && res_ready) || cfg_we)
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        addr_pair_t pair;
        logic       rs;
        logic       need_settle;
        bit         first_phase;
        int         productive;
        int         n_steps;
        int         mode;

        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= REG_SRC_PITCH;
        cfg_data   <= '0;
        step_valid <= 1'b0;
        restart    <= 1'b0;

        p_src_pitch = '0;
        p_src_rows  = '0;
        p_src_win   = '0;
        p_trg_pitch = '0;
        p_trg_rows  = '0;
        p_trg_win   = '0;
        p_bpp       = 3'd1;
        p_mirror    = 1'b0;
        walk_row    = '0;
        walk_col    = '0;
        walk_byte   = '0;
        walk_done   = 1'b1;

        directed_plan = '{
            step_row(1'b0, 1'b1),
            step_row(1'b1, 1'b1),
            cfg_row(REG_SRC_PITCH, 48'd65535),
            cfg_row(REG_SRC_ROWS, 48'd20),
            cfg_row(REG_SRC_WINDOW, pack_window(3, 2, 4, 6)),
            cfg_row(REG_TRG_PITCH, 48'd64),
            cfg_row(REG_TRG_ROWS, 48'h1FFB),
            cfg_row(REG_TRG_WINDOW, pack_window(1, 1, 2, 3)),
            cfg_row(REG_BPP, 48'd0),
            cfg_row(REG_MIRROR, 48'd1),
            step_row(1'b1, 1'b0),
            step_row(1'b0, 1'b0),
            step_row(1'b0, 1'b0),
            step_row(1'b0, 1'b0),
            step_row(1'b0, 1'b0),
            step_row(1'b0, 1'b0),
            step_row(1'b0, 1'b1),
            cfg_row(REG_BPP, 48'd7),
            cfg_row(REG_SRC_WINDOW, pack_window(4095, 4095, 4095, 4095)),
            cfg_row(REG_TRG_PITCH, 48'd65535),
            cfg_row(REG_TRG_WINDOW, pack_window(4095, 4095, 1, 1)),
            step_row(1'b1, 1'b0),
            step_row(1'b0, 1'b0),
            step_row(1'b0, 1'b0),
            step_row(1'b0, 1'b0),
            step_row(1'b0, 1'b1),
            cfg_row(REG_TRG_WINDOW, pack_window(5, 5, 0, 3)),
            step_row(1'b1, 1'b1),
            step_row(1'b0, 1'b1)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        need_settle = 1'b0;
        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (directed_plan[i].kind == ROW_CFG)
            begin
                if (need_settle)
                begin
                    settle();
                    need_settle = 1'b0;
                end
                cfg_write(directed_plan[i].reg_id, directed_plan[i].data);
            end
            else
            begin
                send_step(directed_plan[i].rs, directed_plan[i].idle_result, pair);
                need_settle = 1'b1;
            end
        end

        // Random phases: the walk position carries over each register change.
        productive  = 0;
        first_phase = 1'b1;
        while (productive < STEP_GOAL)
        begin
            settle();
            mode          = $urandom_range(0, 9);
            fast_sender   = ($urandom_range(0, 3) == 0);
            fast_receiver = ($urandom_range(0, 3) == 0);
            if (mode == 0)
            begin
                cfg_write(REG_SRC_PITCH, '1);
                cfg_write(REG_SRC_ROWS, 48'h0FFF);
                cfg_write(REG_SRC_WINDOW, '1);
                cfg_write(REG_TRG_PITCH, '1);
                cfg_write(REG_TRG_ROWS, 48'h1000);
                if ($urandom_range(0, 1) == 0)
                begin
                    cfg_write(REG_TRG_WINDOW, '1);
                end
                else
                begin
                    cfg_write(REG_TRG_WINDOW, pack_window(4095, 4095, $urandom_range(1, 4),
                                                          $urandom_range(1, 4)));
                end
                cfg_write(REG_BPP, '1);
                cfg_write(REG_MIRROR, '1);
            end
            else if (mode == 1)
            begin
                cfg_write(REG_SRC_PITCH, '0);
                cfg_write(REG_SRC_ROWS, '0);
                cfg_write(REG_SRC_WINDOW, '0);
                cfg_write(REG_TRG_PITCH, '0);
                cfg_write(REG_TRG_ROWS, '0);
                cfg_write(REG_TRG_WINDOW, pack_window(0, 0, $urandom_range(1, 6),
                                                      $urandom_range(1, 6)));
                cfg_write(REG_BPP, '0);
                cfg_write(REG_MIRROR, '0);
            end
            else
            begin
                if (first_phase || $urandom_range(0, 1) == 0)
                begin
                    cfg_write(REG_SRC_PITCH, noise());
                end
                if (first_phase || $urandom_range(0, 1) == 0)
                begin
                    cfg_write(REG_SRC_ROWS, noise());
                end
                if (first_phase || $urandom_range(0, 1) == 0)
                begin
                    cfg_write(REG_SRC_WINDOW, pack_window($urandom_range(0, 4095),
                        $urandom_range(0, 4095),
                        ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095)
                                                    : $urandom_range(0, 12),
                        ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095)
                                                    : $urandom_range(0, 12)));
                end
                if (first_phase || $urandom_range(0, 1) == 0)
                begin
                    cfg_write(REG_TRG_PITCH, noise());
                end
                if (first_phase || $urandom_range(0, 1) == 0)
                begin
                    cfg_write(REG_TRG_ROWS, noise());
                end
                if (first_phase || $urandom_range(0, 1) == 0)
                begin
                    cfg_write(REG_TRG_WINDOW, pack_window($urandom_range(0, 4095),
                        $urandom_range(0, 4095), target_extent(), target_extent()));
                end
                if (first_phase || $urandom_range(0, 1) == 0)
                begin
                    cfg_write(REG_BPP, noise());
                end
                if (first_phase || $urandom_range(0, 1) == 0)
                begin
                    cfg_write(REG_MIRROR, noise());
                end
                first_phase = 1'b0;
            end

            n_steps = (mode == 0) ? 40 : $urandom_range(40, 160);
            for (int k = 0; k < n_steps; k++)
            begin
                rs = walk_done ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 99) == 0);
                send_step(rs, 1'b0, pair);
                if (pair.valid_res)
                begin
                    productive++;
                end
            end
        end

        settle();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && pending_pairs.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
